// ===== src/tps_pkg.sv =====
package tps_pkg;

   localparam int QUEUE_DEPTH_DEF = 64;
   localparam int JOB_ID_BITS_DEF = 8;
   localparam int TIME_BITS_DEF   = 20;
   localparam int BURST_BITS      = 16;

   localparam logic FUNC_ADMIT = 1'b0;
   localparam logic FUNC_TICK  = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

endpackage

// ===== src/tps_ram.sv =====
module tps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/two_level_preemptive_queue_scheduler.sv =====
// Channel  Direction  Beat contents
// req      in         tuser: func; tdata: job_id, burst_length, system_class
// rsp      out        tuser: is_tick_result; tdata: admit_dropped .. now
//
// For every beat, the accept cycle reads both queue heads from their RAMs;
// the update, the queue write-back and the load of the result register
// follow in the EXEC state. A new beat is taken once the update is done.
// The update cycle holds while the result register is still full.
// Reset is synchronous; it empties both queues and clears the clock and the
// running job. Queue RAM contents are not cleared.
module two_level_preemptive_queue_scheduler
   import tps_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
   parameter int JOB_ID_BITS = JOB_ID_BITS_DEF,
   parameter int TIME_BITS   = TIME_BITS_DEF,
   localparam int IN_RAW     = JOB_ID_BITS + BURST_BITS + 1,
   localparam int IN_DW      = ((IN_RAW + 7) / 8) * 8,
   localparam int OUT_RAW    = JOB_ID_BITS + 4 * TIME_BITS + 4,
   localparam int OUT_DW     = ((OUT_RAW + 7) / 8) * 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [IN_DW-1:0]  req_tdata,  // job_id, burst_length, system_class, zero pad
   input  logic              req_tuser,  // func
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [OUT_DW-1:0] rsp_tdata,  // admit_dropped, idle, run_job, first_run,
                                         // response_time, finished, turnaround_time,
                                         // waiting_time, now, zero pad
   output logic              rsp_tuser   // is_tick_result
);

   localparam int AW  = $clog2(QUEUE_DEPTH);
   localparam int CNW = $clog2(QUEUE_DEPTH + 1);
   localparam int JW  = JOB_ID_BITS + TIME_BITS + 2 * BURST_BITS + 1;
   localparam int CMW = (TIME_BITS > BURST_BITS) ? TIME_BITS : BURST_BITS;
   localparam logic [CNW-1:0] DEPTH_C = CNW'(QUEUE_DEPTH);
   localparam logic [AW-1:0]  LAST_C  = AW'(QUEUE_DEPTH - 1);

   typedef struct packed {
      logic                   started;
      logic [BURST_BITS-1:0]  remaining;
      logic [BURST_BITS-1:0]  burst;
      logic [TIME_BITS-1:0]   arrival;
      logic [JOB_ID_BITS-1:0] id;
   } job_type;

   state_type state_ff, state_in;

   logic                   func_ff;
   logic [JOB_ID_BITS-1:0] id_ff;
   logic [BURST_BITS-1:0]  burst_ff;
   logic                   class_ff;

   logic [AW-1:0]  sys_head_ff, sys_head_in, sys_tail_ff, sys_tail_in;
   logic [AW-1:0]  usr_head_ff, usr_head_in, usr_tail_ff, usr_tail_in;
   logic [CNW-1:0] sys_cnt_ff, sys_cnt_in, usr_cnt_ff, usr_cnt_in;

   job_type                run_ff, run_in;
   logic                   has_run_ff, has_run_in;
   logic                   run_sys_ff, run_sys_in;
   logic [TIME_BITS-1:0]   time_ff, time_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [OUT_DW-1:0]      rsp_data_ff, rsp_data_in;
   logic                   rsp_user_ff, rsp_user_in;

   logic          accept, go;
   logic          sys_we, usr_we;
   logic [AW-1:0] usr_waddr;
   job_type       new_job, usr_wdata;
   logic [JW-1:0] sys_rdata, usr_rdata;

   job_type              cur;
   logic                 preempt, keep, pop_sys, pop_usr, active, first, fin, dropped;
   logic [TIME_BITS-1:0] t_next, resp, tat, wait_t;
   logic [CMW-1:0]       tat_x, burst_x;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign go         = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_tready);

   assign new_job = '{started: 1'b0, remaining: burst_ff, burst: burst_ff,
                      arrival: time_ff, id: id_ff};

   tps_ram #(.WIDTH(JW), .DEPTH(QUEUE_DEPTH)) u_sys_ram (
      .clock   (clock),
      .wr_en   (sys_we),
      .wr_addr (sys_tail_ff),
      .wr_data (new_job),
      .rd_en   (accept),
      .rd_addr (sys_head_ff),
      .rd_data (sys_rdata)
   );

   tps_ram #(.WIDTH(JW), .DEPTH(QUEUE_DEPTH)) u_usr_ram (
      .clock   (clock),
      .wr_en   (usr_we),
      .wr_addr (usr_waddr),
      .wr_data (usr_wdata),
      .rd_en   (accept),
      .rd_addr (usr_head_ff),
      .rd_data (usr_rdata)
   );

   assign usr_waddr = usr_tail_ff;

   always_comb begin
      state_in     = state_ff;
      sys_head_in  = sys_head_ff;
      sys_tail_in  = sys_tail_ff;
      sys_cnt_in   = sys_cnt_ff;
      usr_head_in  = usr_head_ff;
      usr_tail_in  = usr_tail_ff;
      usr_cnt_in   = usr_cnt_ff;
      run_in       = run_ff;
      has_run_in   = has_run_ff;
      run_sys_in   = run_sys_ff;
      time_in      = time_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      sys_we       = 1'b0;
      usr_we       = 1'b0;
      usr_wdata    = new_job;

      preempt = has_run_ff && !run_sys_ff && (sys_cnt_ff != '0) && (usr_cnt_ff < DEPTH_C);
      keep    = has_run_ff && !preempt;
      pop_sys = !keep && (sys_cnt_ff != '0);
      pop_usr = !keep && (sys_cnt_ff == '0) && (usr_cnt_ff != '0);
      active  = keep || pop_sys || pop_usr;
      cur     = keep ? run_ff : (pop_sys ? job_type'(sys_rdata) : job_type'(usr_rdata));
      first   = active && !cur.started;
      t_next  = (time_ff == '1) ? time_ff : time_ff + 1'b1;
      resp    = first ? (time_ff - cur.arrival) : '0;
      fin     = active && (cur.remaining <= BURST_BITS'(1));
      tat     = t_next - cur.arrival;
      tat_x   = CMW'(tat);
      burst_x = CMW'(cur.burst);
      wait_t  = (tat_x > burst_x) ? TIME_BITS'(tat_x - burst_x) : '0;
      dropped = class_ff ? (sys_cnt_ff >= DEPTH_C) : (usr_cnt_ff >= DEPTH_C);

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (go) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_user_in  = func_ff;
               if (func_ff == FUNC_ADMIT) begin
                  rsp_data_in = OUT_DW'({time_ff, {(3 * TIME_BITS + JOB_ID_BITS + 3){1'b0}},
                                         dropped});
                  if (!dropped) begin
                     if (class_ff) begin
                        sys_we      = 1'b1;
                        sys_tail_in = (sys_tail_ff == LAST_C) ? '0 : sys_tail_ff + 1'b1;
                        sys_cnt_in  = sys_cnt_ff + 1'b1;
                     end else begin
                        usr_we      = 1'b1;
                        usr_tail_in = (usr_tail_ff == LAST_C) ? '0 : usr_tail_ff + 1'b1;
                        usr_cnt_in  = usr_cnt_ff + 1'b1;
                     end
                  end
               end else begin
                  time_in = t_next;
                  if (preempt) begin
                     usr_we      = 1'b1;
                     usr_wdata   = run_ff;
                     usr_tail_in = (usr_tail_ff == LAST_C) ? '0 : usr_tail_ff + 1'b1;
                     usr_cnt_in  = usr_cnt_ff + 1'b1;
                  end
                  if (pop_sys) begin
                     sys_head_in = (sys_head_ff == LAST_C) ? '0 : sys_head_ff + 1'b1;
                     sys_cnt_in  = sys_cnt_ff - 1'b1;
                     run_sys_in  = 1'b1;
                  end
                  if (pop_usr) begin
                     usr_head_in = (usr_head_ff == LAST_C) ? '0 : usr_head_ff + 1'b1;
                     usr_cnt_in  = usr_cnt_ff - 1'b1;
                     run_sys_in  = 1'b0;
                  end
                  has_run_in          = active && !fin;
                  run_in              = cur;
                  run_in.started      = 1'b1;
                  run_in.remaining    = cur.remaining - BURST_BITS'(1);
                  rsp_data_in = OUT_DW'({time_ff,
                                         fin ? wait_t : {TIME_BITS{1'b0}},
                                         fin ? tat : {TIME_BITS{1'b0}},
                                         fin, resp, first,
                                         active ? cur.id : {JOB_ID_BITS{1'b0}},
                                         !active, 1'b0});
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sys_head_ff  <= '0;
         sys_tail_ff  <= '0;
         sys_cnt_ff   <= '0;
         usr_head_ff  <= '0;
         usr_tail_ff  <= '0;
         usr_cnt_ff   <= '0;
         run_ff       <= '0;
         has_run_ff   <= 1'b0;
         run_sys_ff   <= 1'b0;
         time_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sys_head_ff  <= sys_head_in;
         sys_tail_ff  <= sys_tail_in;
         sys_cnt_ff   <= sys_cnt_in;
         usr_head_ff  <= usr_head_in;
         usr_tail_ff  <= usr_tail_in;
         usr_cnt_ff   <= usr_cnt_in;
         run_ff       <= run_in;
         has_run_ff   <= has_run_in;
         run_sys_ff   <= run_sys_in;
         time_ff      <= time_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      if (accept) begin
         func_ff  <= req_tuser;
         id_ff    <= req_tdata[JOB_ID_BITS-1:0];
         burst_ff <= req_tdata[JOB_ID_BITS +: BURST_BITS];
         class_ff <= req_tdata[JOB_ID_BITS + BURST_BITS];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule
